>>> hw/rtl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;
   typedef enum logic [1:0] {
      PATH_TRACE = 2'd0,
      PATH_AX0   = 2'd1,
      PATH_AX1   = 2'd2,
      PATH_AX2   = 2'd3
   } path_type;
endpackage
`default_nettype wire

>>> hw/rtl/rotation_matrix_to_quaternion_top.sv
`default_nettype none
// Rotation matrix to quaternion (Shoemake). Takes nine signed Q2.F matrix entries
// (F = WORD_BITS-2) and returns w, x, y, z saturated to WORD_BITS plus a degenerate flag,
// set when the radicand is zero or negative; all four components are then zero.
// One transaction per clock. The pipeline has one input register,
// WORD_BITS square root stages, one dividend register, 2*WORD_BITS divider stages and one
// output register. The square root is an unrolled pipeline that retires one result bit per
// stage. The three quotients are restoring dividers that also retire one bit per stage.
// A stall holds the whole pipeline.
module rotation_matrix_to_quaternion_top #(
   parameter int WORD_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire signed [WORD_BITS-1:0] req_m_r0_c0,
   input  wire signed [WORD_BITS-1:0] req_m_r0_c1,
   input  wire signed [WORD_BITS-1:0] req_m_r0_c2,
   input  wire signed [WORD_BITS-1:0] req_m_r1_c0,
   input  wire signed [WORD_BITS-1:0] req_m_r1_c1,
   input  wire signed [WORD_BITS-1:0] req_m_r1_c2,
   input  wire signed [WORD_BITS-1:0] req_m_r2_c0,
   input  wire signed [WORD_BITS-1:0] req_m_r2_c1,
   input  wire signed [WORD_BITS-1:0] req_m_r2_c2,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_quat_w,
   output logic signed [WORD_BITS-1:0] rsp_quat_x,
   output logic signed [WORD_BITS-1:0] rsp_quat_y,
   output logic signed [WORD_BITS-1:0] rsp_quat_z,
   output logic                       rsp_degenerate
);
   import rmq_pkg::*;

   localparam int FB   = WORD_BITS - 2;
   localparam int RB   = WORD_BITS + 2;          // radicand, up to 7.0 - eps in Q4.F
   localparam int AB   = RB + FB;                // radicand scaled by 2^F
   localparam int SB   = AB / 2 + AB % 2;        // sqrt bits
   localparam int SN   = SB;                     // sqrt stages
   localparam int DB   = WORD_BITS + 1;          // |d| bits
   localparam int NB   = DB + FB + 1;            // dividend bits
   localparam int DVB  = SB + 1;                 // divisor 2Q bits
   localparam int DN   = NB;                     // divider stages
   localparam int LAT  = 1 + SN + 1 + DN + 1;

   // common pipeline advance
   logic adv;
   logic [LAT-1:0] vld_ff;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- stage 0: path select, radicand, numerators
   logic signed [WORD_BITS+1:0] tr, d00, d11, d22, rad;
   logic signed [DB-1:0] nw, na, nb;
   logic [1:0] ax;
   path_type pth;

   always_comb begin
      d00 = (WORD_BITS+2)'(req_m_r0_c0);
      d11 = (WORD_BITS+2)'(req_m_r1_c1);
      d22 = (WORD_BITS+2)'(req_m_r2_c2);
      tr  = d00 + d11 + d22;
      ax  = 2'd0;
      if (req_m_r1_c1 > req_m_r0_c0) ax = 2'd1;
      if (ax == 2'd0) begin
         if (req_m_r2_c2 > req_m_r0_c0) ax = 2'd2;
      end else begin
         if (req_m_r2_c2 > req_m_r1_c1) ax = 2'd2;
      end
      if (tr > 0) begin
         pth = PATH_TRACE;
         rad = tr + (WORD_BITS+2)'(1 << FB);
         nw  = DB'(req_m_r2_c1) - DB'(req_m_r1_c2);
         na  = DB'(req_m_r0_c2) - DB'(req_m_r2_c0);
         nb  = DB'(req_m_r1_c0) - DB'(req_m_r0_c1);
      end else begin
         unique case (ax)
            2'd0: begin
               pth = PATH_AX0;
               rad = d00 - (d11 + d22) + (WORD_BITS+2)'(1 << FB);
               nw  = DB'(req_m_r2_c1) - DB'(req_m_r1_c2);
               na  = DB'(req_m_r0_c1) + DB'(req_m_r1_c0);
               nb  = DB'(req_m_r0_c2) + DB'(req_m_r2_c0);
            end
            2'd1: begin
               pth = PATH_AX1;
               rad = d11 - (d22 + d00) + (WORD_BITS+2)'(1 << FB);
               nw  = DB'(req_m_r0_c2) - DB'(req_m_r2_c0);
               na  = DB'(req_m_r1_c2) + DB'(req_m_r2_c1);
               nb  = DB'(req_m_r1_c0) + DB'(req_m_r0_c1);
            end
            default: begin
               pth = PATH_AX2;
               rad = d22 - (d00 + d11) + (WORD_BITS+2)'(1 << FB);
               nw  = DB'(req_m_r1_c0) - DB'(req_m_r0_c1);
               na  = DB'(req_m_r2_c0) + DB'(req_m_r0_c2);
               nb  = DB'(req_m_r2_c1) + DB'(req_m_r1_c2);
            end
         endcase
      end
   end

   // per-item side data carried through the pipe
   typedef struct packed {
      path_type          pth;
      logic              deg;
      logic [DB-2:0]     mw, ma, mb;   // magnitudes (max 2^(DB-1))
      logic              zw, za, zb;   // magnitude top bit
      logic              sw, sa, sb;   // signs
   } side_type;

   side_type s0_in;
   logic [AB-1:0] a0_in;
   always_comb begin
      logic [DB-1:0] aw, aa, ab;
      aw = nw[DB-1] ? DB'(-nw) : DB'(nw);
      aa = na[DB-1] ? DB'(-na) : DB'(na);
      ab = nb[DB-1] ? DB'(-nb) : DB'(nb);
      s0_in.pth = pth;
      s0_in.deg = (rad <= 0);
      {s0_in.zw, s0_in.mw} = aw;
      {s0_in.za, s0_in.ma} = aa;
      {s0_in.zb, s0_in.mb} = ab;
      s0_in.sw = nw[DB-1];
      s0_in.sa = na[DB-1];
      s0_in.sb = nb[DB-1];
      a0_in = (rad <= 0) ? '0 : {rad[RB-1:0], {FB{1'b0}}};
   end

   // ---------------- square root stages (restoring digit recurrence, exact)
   side_type      sq_side_ff [SN+1];
   logic [AB-1:0] sq_v_ff    [SN+1];
   logic [SB-1:0] sq_r_ff    [SN+1];
   logic [SB+1:0] sq_rem_ff  [SN+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= s0_in;
         sq_v_ff[0]    <= a0_in;
         sq_r_ff[0]    <= '0;
         sq_rem_ff[0]  <= '0;
      end
   end

   for (genvar g = 0; g < SN; g++) begin : g_sq
      logic [SB+1:0] rem_in, trial;
      logic [SB-1:0] r_in;
      logic [1:0]    pair;
      always_comb begin
         pair   = sq_v_ff[g][AB-1-2*g -: 2];
         rem_in = {sq_rem_ff[g][SB-1:0], pair};
         trial  = (SB+2)'({sq_r_ff[g], 2'b01});
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            r_in   = {sq_r_ff[g][SB-2:0], 1'b1};
         end else begin
            r_in   = {sq_r_ff[g][SB-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_side_ff[g+1] <= sq_side_ff[g];
            sq_v_ff[g+1]    <= sq_v_ff[g];
            sq_r_ff[g+1]    <= r_in;
            sq_rem_ff[g+1]  <= rem_in;
         end
      end
   end

   // ---------------- dividers: (|d|*2^F + Q) / (2Q), one quotient bit per stage
   side_type      dv_side_ff [DN+1];
   logic [SB-1:0] dv_q_ff    [DN+1];
   logic [NB-1:0] dv_nw_ff   [DN+1];
   logic [NB-1:0] dv_na_ff   [DN+1];
   logic [NB-1:0] dv_nb_ff   [DN+1];
   logic [DVB-1:0] dv_rw_ff  [DN+1];
   logic [DVB-1:0] dv_ra_ff  [DN+1];
   logic [DVB-1:0] dv_rb_ff  [DN+1];
   logic [NB-1:0] dv_ow_ff   [DN+1];
   logic [NB-1:0] dv_oa_ff   [DN+1];
   logic [NB-1:0] dv_ob_ff   [DN+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= sq_side_ff[SN];
         dv_q_ff[0]    <= sq_r_ff[SN];
         dv_nw_ff[0] <= NB'({sq_side_ff[SN].zw, sq_side_ff[SN].mw, {FB{1'b0}}})
                        + NB'(sq_r_ff[SN]);
         dv_na_ff[0] <= NB'({sq_side_ff[SN].za, sq_side_ff[SN].ma, {FB{1'b0}}})
                        + NB'(sq_r_ff[SN]);
         dv_nb_ff[0] <= NB'({sq_side_ff[SN].zb, sq_side_ff[SN].mb, {FB{1'b0}}})
                        + NB'(sq_r_ff[SN]);
         dv_rw_ff[0] <= '0;
         dv_ra_ff[0] <= '0;
         dv_rb_ff[0] <= '0;
         dv_ow_ff[0] <= '0;
         dv_oa_ff[0] <= '0;
         dv_ob_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < DN; g++) begin : g_dv
      logic [DVB-1:0] dvs;
      logic [DVB:0]   tw, ta, tb;
      logic [DVB-1:0] rw, ra, rb;
      logic ow, oa, ob;
      always_comb begin
         dvs = {dv_q_ff[g], 1'b0};
         tw = {dv_rw_ff[g], dv_nw_ff[g][NB-1-g]};
         ta = {dv_ra_ff[g], dv_na_ff[g][NB-1-g]};
         tb = {dv_rb_ff[g], dv_nb_ff[g][NB-1-g]};
         ow = (tw >= {1'b0, dvs}); rw = ow ? DVB'(tw - {1'b0, dvs}) : DVB'(tw);
         oa = (ta >= {1'b0, dvs}); ra = oa ? DVB'(ta - {1'b0, dvs}) : DVB'(ta);
         ob = (tb >= {1'b0, dvs}); rb = ob ? DVB'(tb - {1'b0, dvs}) : DVB'(tb);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_side_ff[g+1] <= dv_side_ff[g];
            dv_q_ff[g+1]    <= dv_q_ff[g];
            dv_nw_ff[g+1]   <= dv_nw_ff[g];
            dv_na_ff[g+1]   <= dv_na_ff[g];
            dv_nb_ff[g+1]   <= dv_nb_ff[g];
            dv_rw_ff[g+1]   <= rw;
            dv_ra_ff[g+1]   <= ra;
            dv_rb_ff[g+1]   <= rb;
            dv_ow_ff[g+1]   <= {dv_ow_ff[g][NB-2:0], ow};
            dv_oa_ff[g+1]   <= {dv_oa_ff[g][NB-2:0], oa};
            dv_ob_ff[g+1]   <= {dv_ob_ff[g][NB-2:0], ob};
         end
      end
   end

   // ---------------- output: saturate, sign, route
   localparam logic [NB-1:0] LIM = NB'(1) << (WORD_BITS - 1);

   function automatic logic [WORD_BITS-1:0] sgn_sat(input logic [NB-1:0] m, input logic neg);
      logic [WORD_BITS-1:0] v;
      if (m >= LIM) begin
         v = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
         v = neg ? WORD_BITS'(-m) : WORD_BITS'(m);
      end
      return v;
   endfunction

   logic [WORD_BITS-1:0] hw, cw, ca, cb;
   logic [SB:0] hsum;
   side_type sd;
   always_comb begin
      sd   = dv_side_ff[DN];
      hsum = ({1'b0, dv_q_ff[DN]} + (SB+1)'(1)) >> 1;
      hw   = (hsum >= (SB+1)'(LIM)) ? {1'b0, {(WORD_BITS-1){1'b1}}} : WORD_BITS'(hsum);
      cw   = sgn_sat(dv_ow_ff[DN], sd.sw);
      ca   = sgn_sat(dv_oa_ff[DN], sd.sa);
      cb   = sgn_sat(dv_ob_ff[DN], sd.sb);
   end

   logic [WORD_BITS-1:0] ow_ff, ox_ff, oy_ff, oz_ff;
   logic deg_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         deg_ff <= sd.deg;
         if (sd.deg) begin
            ow_ff <= '0; ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         end else begin
            unique case (sd.pth)
               PATH_TRACE: begin ow_ff <= hw; ox_ff <= cw; oy_ff <= ca; oz_ff <= cb; end
               PATH_AX0:   begin ow_ff <= cw; ox_ff <= hw; oy_ff <= ca; oz_ff <= cb; end
               PATH_AX1:   begin ow_ff <= cw; oy_ff <= hw; oz_ff <= ca; ox_ff <= cb; end
               default:    begin ow_ff <= cw; oz_ff <= hw; ox_ff <= ca; oy_ff <= cb; end
            endcase
         end
      end
   end

   assign rsp_quat_w     = ow_ff;
   assign rsp_quat_x     = ox_ff;
   assign rsp_quat_y     = oy_ff;
   assign rsp_quat_z     = oz_ff;
   assign rsp_degenerate = deg_ff;
endmodule
`default_nettype wire

>>> tb/sv/rotation_matrix_to_quaternion_top_test.sv
`default_nettype none
module rotation_matrix_to_quaternion_top_test;
   localparam int WB = 16;
   localparam int FB = WB - 2;
   localparam longint ONE_Q = 64'sd1 <<< FB;
   localparam longint WMAX = (64'sd1 <<< (WB - 1)) - 1;
   localparam longint WMIN = -WMAX - 1;
   localparam int LATENCY = 3 * WB + 3;
   localparam int NUM_RANDOM = 930;

   typedef logic signed [WB-1:0] word_type;
   typedef word_type mat_type [9];
   typedef struct packed {
      word_type w, x, y, z;
      logic  deg;
   } quat_type;

   logic  clock = 1'b0;
   logic  reset = 1'b1;
   logic  req_valid = 1'b0;
   logic  rsp_stall = 1'b0;
   word_type req_m [9];
   logic  req_stall, rsp_valid, rsp_degenerate;
   word_type rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type quat_queue [$];
   int    mismatch_count = 0;
   int    sent_count = 0;
   int    got_count = 0;
   int    degenerate_count = 0;
   int    path_count [4] = '{0, 0, 0, 0};
   bit    hold_long = 1'b0;
   bit    busy_phase = 1'b1;

   always #4 clock = ~clock;

   initial foreach (req_m[i]) req_m[i] = '0;

   rotation_matrix_to_quaternion_top #(.WORD_BITS(WB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m_r0_c0(req_m[0]), .req_m_r0_c1(req_m[1]), .req_m_r0_c2(req_m[2]),
      .req_m_r1_c0(req_m[3]), .req_m_r1_c1(req_m[4]), .req_m_r1_c2(req_m[5]),
      .req_m_r2_c0(req_m[6]), .req_m_r2_c1(req_m[7]), .req_m_r2_c2(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_degenerate(rsp_degenerate)
   );

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // d * 2^F / (2q), nearest with ties away from zero, saturated
   function automatic word_type root_quotient(longint d, longint q);
      longint mag, res;
      mag = (d < 0) ? -d : d;
      res = ((mag <<< FB) + q) / (q * 2);
      if (d < 0) return (res > -WMIN) ? word_type'(WMIN) : word_type'(-res);
      return (res > WMAX) ? word_type'(WMAX) : word_type'(res);
   endfunction

   function automatic word_type half_root(longint q);
      longint h;
      h = (q + 1) >>> 1;
      return (h > WMAX) ? word_type'(WMAX) : word_type'(h);
   endfunction

   function automatic rmq_pkg::path_type pick_path(mat_type a);
      longint tr;
      int ax;
      tr = longint'(a[0]) + longint'(a[4]) + longint'(a[8]);
      if (tr > 0) return rmq_pkg::PATH_TRACE;
      ax = 0;
      if (a[4] > a[0]) ax = 1;
      if (a[8] > a[ax*4]) ax = 2;
      case (ax)
         0: return rmq_pkg::PATH_AX0;
         1: return rmq_pkg::PATH_AX1;
         default: return rmq_pkg::PATH_AX2;
      endcase
   endfunction

   function automatic quat_type matrix_to_quat(mat_type a);
      longint m [3][3];
      word_type  v [3];
      quat_type  res;
      longint tr, rad, root;
      int     i, j, k;
      rmq_pkg::path_type p;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) m[r][c] = longint'(a[r*3+c]);
      res = '0;
      p = pick_path(a);
      if (p == rmq_pkg::PATH_TRACE) begin
         tr = m[0][0] + m[1][1] + m[2][2];
         root = int_sqrt((tr + ONE_Q) <<< FB);
         res.w = half_root(root);
         res.x = root_quotient(m[2][1] - m[1][2], root);
         res.y = root_quotient(m[0][2] - m[2][0], root);
         res.z = root_quotient(m[1][0] - m[0][1], root);
      end else begin
         i = (p == rmq_pkg::PATH_AX0) ? 0 : (p == rmq_pkg::PATH_AX1) ? 1 : 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         rad = m[i][i] - (m[j][j] + m[k][k]) + ONE_Q;
         if (rad <= 0) begin
            res.deg = 1'b1;
         end else begin
            root = int_sqrt(rad <<< FB);
            v[i] = half_root(root);
            v[j] = root_quotient(m[i][j] + m[j][i], root);
            v[k] = root_quotient(m[i][k] + m[k][i], root);
            res.w = root_quotient(m[k][j] - m[j][k], root);
            res.x = v[0];
            res.y = v[1];
            res.z = v[2];
         end
      end
      return res;
   endfunction

   // directed rows; known marks rows whose result is typed in
   typedef struct {
      mat_type  mat;
      bit    known;
      quat_type want;
   } vector_type;
   vector_type vectors [$];

   function automatic mat_type mk(int a0, int a1, int a2, int a3, int a4, int a5,
                               int a6, int a7, int a8);
      mat_type t;
      t = '{word_type'(a0), word_type'(a1), word_type'(a2), word_type'(a3), word_type'(a4),
            word_type'(a5), word_type'(a6), word_type'(a7), word_type'(a8)};
      return t;
   endfunction

   task automatic add_row(mat_type t, bit known, quat_type want);
      vector_type v;
      v.mat = t; v.known = known; v.want = want;
      vectors.push_back(v);
   endtask

   function automatic quat_type qv(int w, int x, int y, int z, bit d);
      quat_type q;
      q.w = word_type'(w); q.x = word_type'(x); q.y = word_type'(y); q.z = word_type'(z);
      q.deg = d;
      return q;
   endfunction

   task automatic build_directed();
      // identity: w = 1.0
      add_row(mk(16384,0,0, 0,16384,0, 0,0,16384), 1, qv(16384,0,0,0,0));
      // all zero: trace 0, radicand 1.0, root 1.0 -> x = 0.5
      add_row(mk(0,0,0, 0,0,0, 0,0,0), 1, qv(0,8192,0,0,0));
      // 180 deg about x, y, z
      add_row(mk(16384,0,0, 0,-16384,0, 0,0,-16384), 1, qv(0,16384,0,0,0));
      add_row(mk(-16384,0,0, 0,16384,0, 0,0,-16384), 1, qv(0,0,16384,0,0));
      add_row(mk(-16384,0,0, 0,-16384,0, 0,0,16384), 1, qv(0,0,0,16384,0));
      // all-negative diagonal: axis path, radicand stays positive
      add_row(mk(-16384,0,0, 0,-16384,0, 0,0,-16384), 0, '0);
      add_row(mk(-32768,0,0, 0,-32768,0, 0,0,-32768), 0, '0);
      // ties on the diagonal keep the lower axis
      add_row(mk(-8192,100,-200, 300,-8192,400, -500,600,-8192), 0, '0);
      add_row(mk(-16384,1,2, 3,0,4, 5,6,0), 0, '0);
      // field extremes, saturation
      add_row(mk(32767,32767,32767, 32767,32767,32767, 32767,32767,32767), 0, '0);
      add_row(mk(32767,-32768,32767, -32768,32767,-32768, 32767,-32768,32767), 0, '0);
      add_row(mk(-32768,32767,-32768, 32767,-32768,32767, -32768,32767,-32768), 0, '0);
      add_row(mk(32767,-32768,-32768, -32768,-32768,32767, 32767,32767,-32768), 0, '0);
      add_row(mk(1,-32768,32767, 32767,0,-32768, -32768,32767,0), 0, '0);
      // trace just above zero, then axis-path rows with extreme off-diagonals
      add_row(mk(1,32767,-32768, -32768,0,32767, 32767,-32768,0), 0, '0);
      add_row(mk(-16383,32767,32767, 32767,-16384,32767, 32767,32767,-16384), 0, '0);
      add_row(mk(0,-32768,-32768, -32768,-16384,-32768, -32768,-32768,16383), 0, '0);
      // 90 deg about z
      add_row(mk(0,-16384,0, 16384,0,0, 0,0,16384), 0, '0);
   endtask

   function automatic mat_type random_matrix();
      mat_type t;
      int   mode;
      real  ax, ay, az, an, c, s, ux, uy, uz;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
         // proper rotation with small noise
         ax = $urandom_range(0, 2000) - 1000.0;
         ay = $urandom_range(0, 2000) - 1000.0;
         az = $urandom_range(0, 2000) - 1000.0;
         an = $sqrt(ax*ax + ay*ay + az*az) + 1e-9;
         ux = ax/an; uy = ay/an; uz = az/an;
         c = $cos($urandom_range(0, 6283) / 1000.0);
         s = $sin($urandom_range(0, 6283) / 1000.0);
         s = (s*s + c*c > 0) ? s / $sqrt(s*s + c*c) : 0.0;
         c = $sqrt(1.0 - s*s) * ((mode % 2) ? -1.0 : 1.0);
         t[0] = word_type'($rtoi(16384.0*(c + ux*ux*(1-c))));
         t[1] = word_type'($rtoi(16384.0*(ux*uy*(1-c) - uz*s)));
         t[2] = word_type'($rtoi(16384.0*(ux*uz*(1-c) + uy*s)));
         t[3] = word_type'($rtoi(16384.0*(uy*ux*(1-c) + uz*s)));
         t[4] = word_type'($rtoi(16384.0*(c + uy*uy*(1-c))));
         t[5] = word_type'($rtoi(16384.0*(uy*uz*(1-c) - ux*s)));
         t[6] = word_type'($rtoi(16384.0*(uz*ux*(1-c) - uy*s)));
         t[7] = word_type'($rtoi(16384.0*(uz*uy*(1-c) + ux*s)));
         t[8] = word_type'($rtoi(16384.0*(c + uz*uz*(1-c))));
         foreach (t[i]) t[i] = t[i] + word_type'($urandom_range(0, 6)) - word_type'(3);
      end else if (mode < 8) begin
         foreach (t[i]) t[i] = word_type'($urandom());
      end else begin
         // diagonal ties and edge values
         foreach (t[i]) t[i] = word_type'($urandom_range(0, 1) ? 32767 : -32768);
         t[4] = t[0];
         if ($urandom_range(0, 1)) t[8] = t[0];
         if ($urandom_range(0, 1)) t[$urandom_range(0, 8)] = word_type'($urandom());
      end
      return t;
   endfunction

   task automatic send_matrix(mat_type t);
      @(negedge clock);
      while (busy_phase && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      foreach (req_m[i]) req_m[i] <= t[i];
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      quat_queue.push_back(matrix_to_quat(t));
      path_count[pick_path(t)]++;
      sent_count++;
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic report(string what, quat_type want, quat_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR %s: expected w=%0d x=%0d y=%0d z=%0d deg=%0b,%s%0d %0d %0d %0d %0b",
                  what, want.w, want.x, want.y, want.z, want.deg, " got w/x/y/z/deg ",
                  got.w, got.x, got.y, got.z, got.deg);
   endtask

   // result side
   always @(posedge clock) begin
      quat_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.w = rsp_quat_w; got.x = rsp_quat_x; got.y = rsp_quat_y;
         got.z = rsp_quat_z; got.deg = rsp_degenerate;
         got_count++;
         if (got.deg) degenerate_count++;
         if (quat_queue.size() == 0) begin
            report("unexpected transaction", '0, got);
         end else begin
            want = quat_queue.pop_front();
            if (got !== want) report("quaternion", want, got);
         end
      end
   end

   // receiver stall pattern
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < 120; n++) @(negedge clock);
            hold_long = 1'b0;
         end
         rsp_stall <= busy_phase && ($urandom_range(0, 99) < 30);
      end
   end

   task automatic drain();
      while (quat_queue.size() != 0) @(posedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("rotation_matrix_to_quaternion_top: mismatch");
      $finish;
   end

   initial begin
      int r;
      vector_type v;
      build_directed();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < vectors.size(); r++) begin
         v = vectors[r];
         send_matrix(v.mat);
         if (v.known && quat_queue[$] !== v.want)
            report("typed-in row", v.want, quat_queue[$]);
      end
      idle_input();
      drain();

      // fill the pipeline against a held receiver
      hold_long = 1'b1;
      for (r = 0; r < 150; r++) send_matrix(random_matrix());
      idle_input();
      drain();

      for (r = 0; r < NUM_RANDOM - 150; r++) begin
         busy_phase = !(r >= 300 && r < 450);
         send_matrix(random_matrix());
      end
      busy_phase = 1'b1;
      idle_input();
      drain();
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d matrices, %0d results: trace %0d, axis x/y/z %0d/%0d/%0d",
               sent_count, got_count, path_count[0], path_count[1], path_count[2],
               path_count[3]);
      $display("degenerate results %0d, mismatches %0d", degenerate_count, mismatch_count);
      if (mismatch_count == 0 && quat_queue.size() == 0)
         $display("rotation_matrix_to_quaternion_top: match");
      else
         $display("rotation_matrix_to_quaternion_top: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
